@@ src/cmdb_pkg.sv @@
// shared types, constants and log table function for the complex magnitude to decibel core
package cmdb_pkg;

   localparam int unsigned LOG_TABLE_ENTRIES_DEF = 64;
   localparam int unsigned MID_DEPTH_DEF         = 4;
   localparam int unsigned OUT_DEPTH_DEF         = 2;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned MAG_W    = 32;
   localparam int unsigned EXP_W    = 5;
   localparam int unsigned FRAC_W   = 31;
   localparam int unsigned ROM_W    = 17;
   localparam int unsigned LOG_W    = 22;
   localparam int unsigned DIFF_W   = 25;
   localparam int unsigned ABS_W    = 24;
   localparam int unsigned K_W      = 26;
   localparam int unsigned PROD_W   = ABS_W + K_W;
   localparam int unsigned DB_W     = 17;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned LOG_LAT  = 6;
   localparam int unsigned BACK_LAT = LOG_LAT + 3;

   localparam logic [K_W-1:0] K_DB20 = 26'd50504453;
   localparam logic [K_W-1:0] K_DB10 = 26'd25252226;

   localparam logic signed [DB_W-1:0] DB_MIN = -17'sd65536;
   localparam logic signed [DB_W-1:0] DB_MAX = 17'sd65535;

   localparam logic [DIFF_W-1:0]     TWO_LOG_OFFSET = 25'd131072;
   localparam logic [CSR_DATA_W-1:0] REF_RESET      = 32'd65536;
   localparam logic                  SCALE_RESET    = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFERENCE_LEVEL = 1'b0,
      CSR_SCALE_SELECT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag_sq;
      logic             zero;
      logic             last;
   } mag_item_type;

   typedef struct packed {
      logic zero;
      logic last;
   } side_type;

   typedef struct packed {
      logic signed [DB_W-1:0] db_value;
      logic                   zero_flag;
      logic                   last_out;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // log2(1 + k/n) in Q1.16 by square and compare, elaboration time only
   function automatic logic [ROM_W-1:0] log_entry(input int unsigned k, input int unsigned n);
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] x;
      logic [63:0] acc;
      logic [63:0] rnd;
      num = 64'(k) << 30;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         quo = quo << 1;
         if (rem >= 64'(n)) begin
            rem = rem - 64'(n);
            quo[0] = 1'b1;
         end
      end
      x = (64'd1 << 30) + quo;
      acc = '0;
      for (int b = 0; b < 17; b++) begin
         x = (x * x) >> 30;
         acc = acc << 1;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            acc[0] = 1'b1;
         end
      end
      rnd = (acc + 64'd1) >> 1;
      if (k >= n) begin
         rnd = 64'd65536;
      end
      return rnd[ROM_W-1:0];
   endfunction

endpackage

@@ src/cmdb_fifo.sv @@
// small register queue with combinational head read
module cmdb_fifo
   import cmdb_pkg::*;
#(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output fifo_status_type  status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ src/cmdb_front.sv @@
// front end: squares the sample parts, forms the squared magnitude and flags zero
module cmdb_front
   import cmdb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_push,
   input  logic signed [SAMPLE_W-1:0] in_real,
   input  logic signed [SAMPLE_W-1:0] in_imag,
   input  logic                       in_last,
   output logic                       in_full,
   input  fifo_status_type            mid_status,
   output logic                       mid_push,
   output mag_item_type               mid_item
);

   logic                    enable;
   logic                    vld1_ff, vld2_ff;
   logic signed [MAG_W-1:0] sq_re_ff, sq_re_in;
   logic signed [MAG_W-1:0] sq_im_ff, sq_im_in;
   logic                    last1_ff;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    last2_ff;

   assign enable   = !vld2_ff || !mid_status.full;
   assign in_full  = !enable;
   assign mid_push = vld2_ff && !mid_status.full;

   assign sq_re_in = MAG_W'(in_real) * MAG_W'(in_real);
   assign sq_im_in = MAG_W'(in_imag) * MAG_W'(in_imag);
   assign mag_in   = $unsigned(sq_re_ff) + $unsigned(sq_im_ff);

   assign mid_item.mag_sq = mag_ff;
   assign mid_item.zero   = (mag_ff == '0);
   assign mid_item.last   = last2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (enable) begin
         vld1_ff <= in_push;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         last1_ff <= in_last;
         mag_ff   <= mag_in;
         last2_ff <= last1_ff;
      end
   end

endmodule

@@ src/cmdb_log2.sv @@
// pipelined base-2 logarithm: leading one, normalise, table with interpolation
module cmdb_log2
   import cmdb_pkg::*;
#(
   parameter int unsigned ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [MAG_W-1:0] operand,
   output logic [LOG_W-1:0] log_value
);

   localparam int unsigned IDX_W  = $clog2(ENTRIES);
   localparam int unsigned ROM_AW = $clog2(ENTRIES + 1);
   localparam int unsigned P_W    = FRAC_W + ROM_AW;
   localparam int unsigned IP_W   = ROM_W + FRAC_W;

   logic [ROM_W-1:0] rom [ENTRIES + 1];

   for (genvar g = 0; g <= ENTRIES; g++) begin : g_rom
      assign rom[g] = log_entry(g, ENTRIES);
   end

   logic [EXP_W-1:0]  e1_ff, e1_in;
   logic [MAG_W-1:0]  x1_ff;
   logic [EXP_W-1:0]  e2_ff;
   logic [FRAC_W-1:0] f2_ff, f2_in;
   logic [MAG_W-1:0]  shifted;
   logic [EXP_W-1:0]  e3_ff;
   logic [P_W-1:0]    p3_ff, p3_in;
   logic [EXP_W-1:0]  e4_ff;
   logic [ROM_W-1:0]  lo4_ff, lo4_in;
   logic [ROM_W-1:0]  d4_ff, d4_in;
   logic [FRAC_W-1:0] rem4_ff;
   logic [ROM_W-1:0]  hi4;
   logic [ROM_AW-1:0] idx_lo;
   logic [ROM_AW-1:0] idx_hi;
   logic [EXP_W-1:0]  e5_ff;
   logic [ROM_W-1:0]  lo5_ff;
   logic [ROM_W-1:0]  frac5_ff, frac5_in;
   logic [IP_W-1:0]   interp;
   logic [LOG_W-1:0]  log_ff, log_in;

   always_comb begin
      e1_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (operand[i]) begin
            e1_in = EXP_W'(i);
         end
      end
   end

   assign shifted = x1_ff << (EXP_W'(MAG_W - 1) - e1_ff);
   assign f2_in   = shifted[FRAC_W-1:0];

   assign p3_in = P_W'(f2_ff) * P_W'(ENTRIES);

   assign idx_lo = ROM_AW'(p3_ff[FRAC_W +: IDX_W]);
   assign idx_hi = idx_lo + ROM_AW'(1);
   assign lo4_in = rom[idx_lo];
   assign hi4    = rom[idx_hi];
   assign d4_in  = (hi4 > lo4_in) ? hi4 - lo4_in : '0;

   assign interp   = IP_W'(d4_ff) * IP_W'(rem4_ff);
   assign frac5_in = interp[FRAC_W +: ROM_W];

   assign log_in = LOG_W'({e5_ff, 16'b0}) + LOG_W'(lo5_ff) + LOG_W'(frac5_ff);

   assign log_value = log_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_ff    <= e1_in;
         x1_ff    <= operand;
         e2_ff    <= e1_ff;
         f2_ff    <= f2_in;
         e3_ff    <= e2_ff;
         p3_ff    <= p3_in;
         e4_ff    <= e3_ff;
         lo4_ff   <= lo4_in;
         d4_ff    <= d4_in;
         rem4_ff  <= p3_ff[FRAC_W-1:0];
         e5_ff    <= e4_ff;
         lo5_ff   <= lo4_ff;
         frac5_ff <= frac5_in;
         log_ff   <= log_in;
      end
   end

endmodule

@@ src/cmdb_back.sv @@
// back end: logs of magnitude and reference, decibel scaling, rounding and saturation
module cmdb_back
   import cmdb_pkg::*;
#(
   parameter int unsigned LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fifo_status_type       mid_status,
   input  mag_item_type          mid_item,
   output logic                  mid_pop,
   input  logic [CSR_DATA_W-1:0] reference_level,
   input  logic                  scale_select,
   input  fifo_status_type       out_status,
   output logic                  out_push,
   output result_type            out_item
);

   logic                     enable;
   logic [BACK_LAT-1:0]      vld_ff;
   side_type                 side_ff [BACK_LAT];
   logic [MAG_W-1:0]         ref_operand;
   logic [LOG_W-1:0]         log_mag;
   logic [LOG_W-1:0]         log_ref;
   logic signed [DIFF_W-1:0] d2;
   logic [DIFF_W-1:0]        d2_neg;
   logic                     neg_ff, neg_in;
   logic [ABS_W-1:0]         abs_ff, abs_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic                     neg8_ff;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W:0]          rounded;
   logic [18:0]              q;
   logic signed [DB_W-1:0]   db_ff, db_in;

   assign enable   = !vld_ff[BACK_LAT-1] || !out_status.full;
   assign mid_pop  = enable && !mid_status.empty;
   assign out_push = vld_ff[BACK_LAT-1] && !out_status.full;

   assign ref_operand = (reference_level == '0) ? MAG_W'(1) : reference_level;

   cmdb_log2 #(.ENTRIES(LOG_TABLE_ENTRIES)) u_log_mag (
      .clock     (clock),
      .enable    (enable),
      .operand   (mid_item.mag_sq),
      .log_value (log_mag)
   );

   cmdb_log2 #(.ENTRIES(LOG_TABLE_ENTRIES)) u_log_ref (
      .clock     (clock),
      .enable    (enable),
      .operand   (ref_operand),
      .log_value (log_ref)
   );

   assign d2 = $signed(DIFF_W'(log_mag)) - $signed({2'b0, log_ref, 1'b0})
               + $signed(TWO_LOG_OFFSET);
   assign d2_neg = -d2;
   assign neg_in = d2[DIFF_W-1];
   assign abs_in = neg_in ? d2_neg[ABS_W-1:0] : d2[ABS_W-1:0];
   assign k_in   = scale_select ? K_DB20 : K_DB10;

   assign prod_in = PROD_W'(abs_ff) * PROD_W'(k_ff);

   assign rounded = (PROD_W + 1)'(prod_ff) + ((PROD_W + 1)'(1) << 31);
   assign q       = rounded[PROD_W -: 19];

   always_comb begin
      if (side_ff[BACK_LAT-2].zero) begin
         db_in = DB_MIN;
      end else if (neg8_ff) begin
         db_in = (q > 19'd65536) ? DB_MIN : -$signed(q[DB_W-1:0]);
      end else begin
         db_in = (q > 19'd65535) ? DB_MAX : $signed(q[DB_W-1:0]);
      end
   end

   assign out_item.db_value  = db_ff;
   assign out_item.zero_flag = side_ff[BACK_LAT-1].zero;
   assign out_item.last_out  = side_ff[BACK_LAT-1].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[BACK_LAT-2:0], !mid_status.empty};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0].zero <= mid_item.zero;
         side_ff[0].last <= mid_item.last;
         for (int i = 1; i < BACK_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         neg_ff  <= neg_in;
         abs_ff  <= abs_in;
         k_ff    <= k_in;
         neg8_ff <= neg_ff;
         prod_ff <= prod_in;
         db_ff   <= db_in;
      end
   end

endmodule

@@ src/complex_magnitude_to_db_core.sv @@
// top level of the complex magnitude to decibel core
//
//   channel  direction  handshake          payload
//   req      in         req_push/req_full  req_real_part, req_imag_part, req_last_in
//   rsp      out        rsp_pop/rsp_empty  rsp_db_value, rsp_zero_flag, rsp_last_out
//   csr      in         csr_write          csr_index, csr_wdata
//
// one transaction per clock sustained while results are popped; the path runs through
// (2 front stages, mid queue, 9 back stages through the two log pipelines, result queue)
// the log pipelines with their table lookup and two multipliers set the stage count
// reset clears the queues and valid chains; registers return to 1.0 and factor 20
// front and back stall on their own, separated by the mid queue
module complex_magnitude_to_db_core
   import cmdb_pkg::*;
#(
   parameter int unsigned LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF,
   parameter int unsigned MID_DEPTH         = MID_DEPTH_DEF,
   parameter int unsigned OUT_DEPTH         = OUT_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_real_part,
   input  logic signed [SAMPLE_W-1:0] req_imag_part,
   input  logic                       req_last_in,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [DB_W-1:0]     rsp_db_value,
   output logic                       rsp_zero_flag,
   output logic                       rsp_last_out,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic [CSR_DATA_W-1:0] reference_level_ff;
   logic                  scale_select_ff;

   fifo_status_type mid_status;
   fifo_status_type out_status;
   mag_item_type    front_item;
   mag_item_type    mid_item;
   logic            mid_push;
   logic            mid_pop;
   logic [$bits(mag_item_type)-1:0] mid_rd;
   result_type      back_item;
   result_type      out_item;
   logic            out_push;
   logic [$bits(result_type)-1:0]   out_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_level_ff <= REF_RESET;
         scale_select_ff    <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_REFERENCE_LEVEL: reference_level_ff <= csr_wdata;
            CSR_SCALE_SELECT:    scale_select_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   cmdb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_push    (req_push),
      .in_real    (req_real_part),
      .in_imag    (req_imag_part),
      .in_last    (req_last_in),
      .in_full    (req_full),
      .mid_status (mid_status),
      .mid_push   (mid_push),
      .mid_item   (front_item)
   );

   cmdb_fifo #(.WIDTH($bits(mag_item_type)), .DEPTH(MID_DEPTH)) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (front_item),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .status  (mid_status)
   );

   assign mid_item = mid_rd;

   cmdb_back #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .mid_status      (mid_status),
      .mid_item        (mid_item),
      .mid_pop         (mid_pop),
      .reference_level (reference_level_ff),
      .scale_select    (scale_select_ff),
      .out_status      (out_status),
      .out_push        (out_push),
      .out_item        (back_item)
   );

   cmdb_fifo #(.WIDTH($bits(result_type)), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (back_item),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .status  (out_status)
   );

   assign out_item      = out_rd;
   assign rsp_empty     = out_status.empty;
   assign rsp_db_value  = out_item.db_value;
   assign rsp_zero_flag = out_item.zero_flag;
   assign rsp_last_out  = out_item.last_out;

`ifndef ASSERT_OFF
   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_zero_flag) |-> (rsp_db_value == DB_MIN))
      else $error("zero flag without saturated result");

   a_full_from_mid: assert property (@(posedge clock) disable iff (reset)
      req_full |-> mid_status.full)
      else $error("input stalled while mid queue has room");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result waiting right after reset");
`endif

endmodule

@@ tb/sv/complex_magnitude_to_db_core_tb.sv @@
// testbench for the complex magnitude to decibel core with a bit-exact predictor
module complex_magnitude_to_db_core_tb
   import cmdb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_POINTS  = LOG_TABLE_ENTRIES_DEF;
   localparam int unsigned PIPE_LATENCY  = 13;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned PHASE_ITEMS   = 210;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned DIRECTED_ROWS = 18;

   typedef enum logic {
      ROW_PREDICTED,
      ROW_FIXED
   } row_kind_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] real_part;
      logic signed [SAMPLE_W-1:0] imag_part;
      logic                       last;
      row_kind_type               kind;
      result_type                 fixed;
   } directed_row_type;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{16'sh0000, 16'sh0000, 1'b0, ROW_FIXED,     '{DB_MIN, 1'b1, 1'b0}},
      '{16'sh0000, 16'sh0000, 1'b1, ROW_FIXED,     '{DB_MIN, 1'b1, 1'b1}},
      '{16'sh8000, 16'sh0000, 1'b0, ROW_FIXED,     '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0000, 16'sh8000, 1'b1, ROW_FIXED,     '{17'sd0, 1'b0, 1'b1}},
      '{16'sh8000, 16'sh8000, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh7FFF, 16'sh7FFF, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh7FFF, 16'sh8000, 1'b1, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh8000, 16'sh7FFF, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0001, 16'sh0000, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0000, 16'shFFFF, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'shFFFF, 16'shFFFF, 1'b1, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0001, 16'sh0001, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0100, 16'sh0000, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh5A82, 16'sh5A82, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh7FFF, 16'sh0000, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh0000, 16'sh7FFF, 1'b1, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'sh5555, 16'shAAAA, 1'b0, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}},
      '{16'shAAAA, 16'sh5555, 1'b1, ROW_PREDICTED, '{17'sd0, 1'b0, 1'b0}}
   };

   localparam logic [CSR_DATA_W-1:0] PHASE_REF [PHASE_COUNT] = '{
      32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_8000, 32'h7FFF_FFFF, 32'h0123_4567, 32'hFFFF_FFFF
   };
   localparam logic PHASE_SCALE [PHASE_COUNT] = '{
      1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
   };

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_push      = 1'b0;
   logic                       req_full;
   logic signed [SAMPLE_W-1:0] req_real_part = '0;
   logic signed [SAMPLE_W-1:0] req_imag_part = '0;
   logic                       req_last_in   = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop       = 1'b0;
   logic signed [DB_W-1:0]     rsp_db_value;
   logic                       rsp_zero_flag;
   logic                       rsp_last_out;
   logic                       csr_write     = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index     = CSR_REFERENCE_LEVEL;
   logic [CSR_DATA_W-1:0]      csr_wdata     = '0;

   logic [ROM_W-1:0]      log_table [0:TABLE_POINTS];
   logic [CSR_DATA_W-1:0] ref_level_mirror = REF_RESET;
   logic                  scale_mirror     = SCALE_RESET;
   result_type            db_due [$];
   int unsigned           mismatch_count = 0;
   int unsigned           quiet_cycles   = 0;
   int unsigned           req_idle_pct   = 0;
   int unsigned           rsp_stall_pct  = 0;

   complex_magnitude_to_db_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .req_last_in   (req_last_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_db_value  (rsp_db_value),
      .rsp_zero_flag (rsp_zero_flag),
      .rsp_last_out  (rsp_last_out),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // log2(1 + k/n) in Q1.16, square and compare on a Q2.30 operand
   function automatic void fill_log_table();
      longint unsigned x;
      longint unsigned acc;
      for (int k = 0; k < TABLE_POINTS; k++) begin
         x   = (64'd1 << 30) + ((64'(k) << 30) / TABLE_POINTS);
         acc = 0;
         for (int b = 0; b < 17; b++) begin
            x   = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd1 << 31)) begin
               x   = x >> 1;
               acc = acc | 64'd1;
            end
         end
         log_table[k] = ROM_W'((acc + 64'd1) >> 1);
      end
      log_table[TABLE_POINTS] = ROM_W'(65536);
   endfunction

   function automatic longint log2_q16(input longint unsigned x);
      int              e;
      longint unsigned frac;
      longint unsigned prod;
      longint unsigned idx;
      longint unsigned rem;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned slope;
      e = 31;
      while (e > 0 && x[e] == 1'b0) e--;
      frac = (x << (31 - e)) & 64'h7FFF_FFFF;
      prod = frac * TABLE_POINTS;
      idx  = prod >> 31;
      if (idx > TABLE_POINTS - 1) begin
         idx = TABLE_POINTS - 1;
      end
      rem   = prod & 64'h7FFF_FFFF;
      lo    = log_table[idx];
      hi    = log_table[idx + 1];
      slope = (hi > lo) ? hi - lo : 64'd0;
      return longint'((64'(e) << 16) + lo + ((slope * rem) >> 31));
   endfunction

   function automatic result_type predict_db(input logic signed [SAMPLE_W-1:0] re,
                                             input logic signed [SAMPLE_W-1:0] im,
                                             input logic last);
      longint          sq;
      longint unsigned ref_eff;
      longint          twice_log;
      longint          k;
      longint unsigned mag;
      longint          q;
      result_type      r;
      sq         = longint'(re) * longint'(re) + longint'(im) * longint'(im);
      r.last_out = last;
      if (sq == 0) begin
         r.db_value  = DB_MIN;
         r.zero_flag = 1'b1;
      end else begin
         ref_eff   = (ref_level_mirror == '0) ? 64'd1 : 64'(ref_level_mirror);
         twice_log = log2_q16(sq) - 2 * log2_q16(ref_eff) + longint'(TWO_LOG_OFFSET);
         k         = scale_mirror ? longint'(K_DB20) : longint'(K_DB10);
         mag       = (twice_log < 0 ? -twice_log : twice_log) * k;
         q         = longint'((mag + (64'd1 << 31)) >> 32);
         if (twice_log < 0) begin
            q = -q;
         end
         if (q < longint'(DB_MIN)) begin
            q = longint'(DB_MIN);
         end
         if (q > longint'(DB_MAX)) begin
            q = longint'(DB_MAX);
         end
         r.db_value  = DB_W'(q);
         r.zero_flag = 1'b0;
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_component();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(7))
         0: begin
            v = '0;
         end
         1: begin
            case ($urandom_range(3))
               0:       v = 16'sh8000;
               1:       v = 16'sh7FFF;
               2:       v = 16'sh0001;
               default: v = 16'shFFFF;
            endcase
         end
         2: begin
            v = SAMPLE_W'($urandom_range(31)) - 16'sd16;
         end
         3: begin
            v = $signed(SAMPLE_W'($urandom)) >>> $urandom_range(15);
         end
         default: begin
            v = SAMPLE_W'($urandom);
         end
      endcase
      return v;
   endfunction

   function automatic void check_result();
      result_type want;
      if (db_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result with none outstanding: db %0d zero %0b last %0b",
                     $time, rsp_db_value, rsp_zero_flag, rsp_last_out);
         end
      end else begin
         want = db_due.pop_front();
         if (rsp_db_value !== want.db_value || rsp_zero_flag !== want.zero_flag ||
             rsp_last_out !== want.last_out) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: expected db %0d zero %0b last %0b, got db %0d zero %0b last %0b",
                        $time, want.db_value, want.zero_flag, want.last_out,
                        rsp_db_value, rsp_zero_flag, rsp_last_out);
            end
         end
      end
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im,
                              input logic last, input result_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      req_last_in   <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      db_due.push_back(want);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (db_due.size() != 0);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] ref_level, input logic scale);
      csr_write <= 1'b1;
      csr_index <= CSR_REFERENCE_LEVEL;
      csr_wdata <= ref_level;
      @(posedge clock);
      csr_index <= CSR_SCALE_SELECT;
      csr_wdata <= CSR_DATA_W'(scale);
      @(posedge clock);
      csr_write        <= 1'b0;
      ref_level_mirror = ref_level;
      scale_mirror     = scale;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_pop && !rsp_empty) begin
            check_result();
         end
      end
      rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      result_type                 want;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       last;
      logic [CSR_DATA_W-1:0]      ref_pick;
      idle_mode_type              mode;
      fill_log_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_FIXED) begin
            want = DIRECTED[i].fixed;
         end else begin
            want = predict_db(DIRECTED[i].real_part, DIRECTED[i].imag_part, DIRECTED[i].last);
         end
         push_sample(DIRECTED[i].real_part, DIRECTED[i].imag_part, DIRECTED[i].last, want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         ref_pick = (phase == 6) ? CSR_DATA_W'($urandom) : PHASE_REF[phase];
         set_config(ref_pick, PHASE_SCALE[phase]);
         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            IDLE_SENDER: begin
               req_idle_pct  = 60;
               rsp_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 60;
            end
            default: begin
               req_idle_pct  = 32;
               rsp_stall_pct = 32;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            re   = random_component();
            im   = random_component();
            last = ($urandom_range(7) == 0);
            push_sample(re, im, last, predict_db(re, im, last));
         end
      end

      drain_results();
      if (mismatch_count == 0 && db_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
